// ----- hw/rtl/pm25_humidity_correction_assert.svh -----
// Assertion macros used by the PM2.5 correction checker.
`ifndef PM25_HUMIDITY_CORRECTION_ASSERT_SVH
`define PM25_HUMIDITY_CORRECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PM25C_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pm25c assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PM25C_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pm25c assertion failed");

`endif

// ----- hw/rtl/pm25c_pkg.sv -----
// Types, constants and lookup tables for the PM2.5 humidity correction pipeline.
package pm25c_pkg;

    localparam longint QONE = longint'(1) << 20;

    // Q.20 coefficients
    localparam logic [19:0] K_SLOPE_LOW  = 20'd549454;
    localparam logic [19:0] K_SLOPE_MID  = 20'd824181;
    localparam logic [19:0] K_SLOPE_HIGH = 20'd723517;
    localparam logic [16:0] K_HUMID      = 17'd90387;
    localparam logic [22:0] K_OFS_LOW    = 23'd6029312;
    localparam logic [22:0] K_OFS_HIGH   = 23'd3110076;
    localparam logic [9:0]  K_QUAD       = 10'd927;

    // Segment breakpoints
    localparam logic [9:0] BRK_A = 10'd30;
    localparam logic [9:0] BRK_B = 10'd50;
    localparam logic [9:0] BRK_C = 10'd210;
    localparam logic [9:0] BRK_D = 10'd260;

    localparam int SPAN_B   = 20;
    localparam int SPAN_D   = 50;
    localparam int IDX_B_W  = $clog2(SPAN_B);
    localparam int IDX_D_W  = $clog2(SPAN_D);

    localparam logic signed [11:0] OUT_MIN = -12'sd4;
    localparam logic signed [11:0] OUT_MAX = 12'sd2047;

    typedef enum logic [2:0] {
        SEG_LOW,
        SEG_RAMP,
        SEG_MID,
        SEG_BEND,
        SEG_HIGH
    } seg_t;

    typedef logic [SPAN_B-1:0][19:0] slope_b_arr_t;
    typedef logic [SPAN_D-1:0][19:0] q20_d_arr_t;
    typedef logic [SPAN_D-1:0][20:0] q21_d_arr_t;
    typedef logic [SPAN_D-1:0][22:0] cst_d_arr_t;

    function automatic slope_b_arr_t build_slope_b();
        slope_b_arr_t tab;
        longint t;
        for (int i = 0; i < SPAN_B; i++) begin
            t = (longint'(i) * QONE) / SPAN_B;
            tab[i] = 20'((longint'(K_SLOPE_MID) * t) / QONE
                        + (longint'(K_SLOPE_LOW) * (QONE - t)) / QONE);
        end
        return tab;
    endfunction

    function automatic q20_d_arr_t build_t_d();
        q20_d_arr_t tab;
        for (int i = 0; i < SPAN_D; i++) begin
            tab[i] = 20'((longint'(i) * QONE) / SPAN_D);
        end
        return tab;
    endfunction

    function automatic q21_d_arr_t build_u_d();
        q21_d_arr_t tab;
        for (int i = 0; i < SPAN_D; i++) begin
            tab[i] = 21'(QONE - (longint'(i) * QONE) / SPAN_D);
        end
        return tab;
    endfunction

    function automatic q20_d_arr_t build_slope_d();
        q20_d_arr_t tab;
        longint t;
        for (int i = 0; i < SPAN_D; i++) begin
            t = (longint'(i) * QONE) / SPAN_D;
            tab[i] = 20'((longint'(K_SLOPE_HIGH) * t) / QONE
                        + (longint'(K_SLOPE_MID) * (QONE - t)) / QONE);
        end
        return tab;
    endfunction

    function automatic cst_d_arr_t build_cst_d();
        cst_d_arr_t tab;
        longint t;
        for (int i = 0; i < SPAN_D; i++) begin
            t = (longint'(i) * QONE) / SPAN_D;
            tab[i] = 23'((longint'(K_OFS_HIGH) * t) / QONE
                        + (longint'(K_OFS_LOW) * (QONE - t)) / QONE);
        end
        return tab;
    endfunction

    localparam slope_b_arr_t SLOPE_B = build_slope_b();
    localparam q20_d_arr_t   T_D     = build_t_d();
    localparam q21_d_arr_t   U_D     = build_u_d();
    localparam q20_d_arr_t   SLOPE_D = build_slope_d();
    localparam cst_d_arr_t   CST_D   = build_cst_d();

    // Stage 1: decoded segment, lookups, square and humidity term
    typedef struct packed {
        seg_t        seg;
        logic [9:0]  x;
        logic [19:0] xx;
        logic [23:0] humid;
        logic [19:0] slope;
        logic [19:0] t;
        logic [20:0] u;
        logic [22:0] cst;
    } s1_t;

    // Stage 2: products
    typedef struct packed {
        seg_t        seg;
        logic [19:0] t;
        logic [22:0] cst;
        logic [29:0] quad;
        logic [29:0] slope_x;
        logic [23:0] hterm;
    } s2_t;

    // Stage 3: linear part and quadratic term
    typedef struct packed {
        logic signed [31:0] base;
        logic [29:0]        qterm;
    } s3_t;

endpackage

// ----- hw/rtl/pm25_humidity_correction.sv -----
// Top level of the PM2.5 humidity correction pipeline.
//
//   channel   direction   handshake             payload
//   input     in          in_valid / in_ready   pm_reading[9:0], humidity[6:0]
//   output    out         out_valid / out_ready corrected_pm[11:0] signed
//
// One word accepted per cycle unless the output stalls; out_valid rises once the word has passed every stage.
// Stages: decode and lookup, products, blend, final sum, truncate and saturate.
// Every stage holds its own valid bit, so bubbles are squeezed out under a stall.
// A stall at the output backs up stage by stage; no word is lost or repeated.
// rst_n clears all valid bits asynchronously; payload registers are not reset.
module pm25_humidity_correction (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [9:0]         pm_reading,
    input  logic [6:0]         humidity,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [11:0] corrected_pm
);
    import pm25c_pkg::*;

    logic v1, r1, v2, r2, v3, r3;
    s1_t  w1;
    s2_t  w2;
    s3_t  w3;

    pm25c_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pm_reading (pm_reading),
        .humidity   (humidity),
        .out_valid  (v1),
        .out_ready  (r1),
        .out_word   (w1)
    );

    pm25c_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_word   (w1),
        .out_valid (v2),
        .out_ready (r2),
        .out_word  (w2)
    );

    pm25c_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in_ready  (r2),
        .in_word   (w2),
        .out_valid (v3),
        .out_ready (r3),
        .out_word  (w3)
    );

    pm25c_final u_final (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v3),
        .in_ready     (r3),
        .in_word      (w3),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .corrected_pm (corrected_pm)
    );

endmodule

// ----- hw/rtl/pm25c_front.sv -----
// Stage 1: segment decode, table lookup, square and humidity products.
module pm25c_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [9:0]       pm_reading,
    input  logic [6:0]       humidity,
    output logic             out_valid,
    input  logic             out_ready,
    output pm25c_pkg::s1_t   out_word
);
    import pm25c_pkg::*;

    logic                valid_reg;
    s1_t                 word_reg;
    s1_t                 word_next;
    logic [9:0]          diff_b;
    logic [9:0]          diff_d;
    logic [IDX_B_W-1:0]  idx_b;
    logic [IDX_D_W-1:0]  idx_d;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    assign diff_b = pm_reading - BRK_A;
    assign diff_d = pm_reading - BRK_C;

    always_comb
    begin
        word_next       = '0;
        word_next.x     = pm_reading;
        word_next.xx    = 20'(pm_reading) * 20'(pm_reading);
        word_next.humid = 24'(K_HUMID) * 24'(humidity);
        if (pm_reading < BRK_A)
            word_next.seg = SEG_LOW;
        else if (pm_reading < BRK_B)
            word_next.seg = SEG_RAMP;
        else if (pm_reading < BRK_C)
            word_next.seg = SEG_MID;
        else if (pm_reading < BRK_D)
            word_next.seg = SEG_BEND;
        else
            word_next.seg = SEG_HIGH;

        // keep the table index in range outside its segment
        idx_b = (word_next.seg == SEG_RAMP) ? diff_b[IDX_B_W-1:0] : '0;
        idx_d = (word_next.seg == SEG_BEND) ? diff_d[IDX_D_W-1:0] : '0;

        unique case (word_next.seg)
            SEG_LOW:
            begin
                word_next.slope = K_SLOPE_LOW;
                word_next.cst   = K_OFS_LOW;
            end
            SEG_RAMP:
            begin
                word_next.slope = SLOPE_B[idx_b];
                word_next.cst   = K_OFS_LOW;
            end
            SEG_MID:
            begin
                word_next.slope = K_SLOPE_MID;
                word_next.cst   = K_OFS_LOW;
            end
            SEG_BEND:
            begin
                word_next.slope = SLOPE_D[idx_d];
                word_next.t     = T_D[idx_d];
                word_next.u     = U_D[idx_d];
                word_next.cst   = CST_D[idx_d];
            end
            default:
            begin
                word_next.slope = K_SLOPE_HIGH;
                word_next.cst   = K_OFS_HIGH;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

endmodule

// ----- hw/rtl/pm25c_mult.sv -----
// Stage 2: slope times reading, quadratic coefficient, and a full, blended or zero humidity term.
module pm25c_mult (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pm25c_pkg::s1_t   in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output pm25c_pkg::s2_t   out_word
);
    import pm25c_pkg::*;

    logic        valid_reg;
    s2_t         word_reg;
    s2_t         word_next;
    logic [44:0] humid_u;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    assign humid_u = 45'(in_word.humid) * 45'(in_word.u);

    always_comb
    begin
        word_next.seg     = in_word.seg;
        word_next.t       = in_word.t;
        word_next.cst     = in_word.cst;
        word_next.quad    = 30'(in_word.xx) * 30'(K_QUAD);
        word_next.slope_x = 30'(in_word.slope) * 30'(in_word.x);
        case (in_word.seg)
            SEG_BEND: word_next.hterm = humid_u[43:20];
            SEG_HIGH: word_next.hterm = '0;
            default:  word_next.hterm = in_word.humid;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

endmodule

// ----- hw/rtl/pm25c_blend.sv -----
// Stage 3: linear sum and the blended, full or zero quadratic term.
module pm25c_blend (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pm25c_pkg::s2_t   in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output pm25c_pkg::s3_t   out_word
);
    import pm25c_pkg::*;

    logic        valid_reg;
    s3_t         word_reg;
    s3_t         word_next;
    logic [49:0] quad_t;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    assign quad_t = 50'(in_word.quad) * 50'(in_word.t);

    always_comb
    begin
        word_next.base = $signed({2'b00, in_word.slope_x})
                       - $signed({8'b0, in_word.hterm})
                       + $signed({9'b0, in_word.cst});
        case (in_word.seg)
            SEG_BEND: word_next.qterm = quad_t[49:20];
            SEG_HIGH: word_next.qterm = in_word.quad;
            default:  word_next.qterm = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

endmodule

// ----- hw/rtl/pm25c_final.sv -----
// Stages 4 and 5: final sum, truncation toward zero, saturation, output register.
module pm25c_final (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pm25c_pkg::s3_t     in_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [11:0] corrected_pm
);
    import pm25c_pkg::*;

    logic                sum_valid_reg;
    logic signed [32:0]  total_reg;
    logic signed [32:0]  total_next;
    logic                sum_ready;
    logic                out_valid_reg;
    logic signed [11:0]  out_reg;
    logic signed [11:0]  out_next;
    logic signed [33:0]  biased;
    logic signed [13:0]  whole;

    assign sum_ready = !out_valid_reg || out_ready;
    assign in_ready  = !sum_valid_reg || sum_ready;
    assign out_valid = out_valid_reg;
    assign corrected_pm = out_reg;

    assign total_next = 33'(in_word.base) + $signed({3'b000, in_word.qterm});

    always_comb
    begin
        // bias negative values so the arithmetic shift truncates toward zero
        biased = 34'(total_reg) + (total_reg[32] ? 34'(QONE - 1) : 34'sd0);
        whole  = biased[33:20];
        if (whole < 14'(OUT_MIN))
            out_next = OUT_MIN;
        else if (whole > 14'(OUT_MAX))
            out_next = OUT_MAX;
        else
            out_next = whole[11:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                sum_valid_reg <= in_valid;
            if (sum_ready)
                out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            total_reg <= total_next;
        if (sum_ready && sum_valid_reg)
            out_reg <= out_next;
    end

endmodule

// ----- hw/rtl/pm25c_checker.sv -----
// Port-level checker for the PM2.5 humidity correction block, with its bind.
`include "pm25_humidity_correction_assert.svh"

module pm25c_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [9:0]         pm_reading,
    input logic [6:0]         humidity,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [11:0] corrected_pm
);

    // a waiting input word holds
    `PM25C_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(pm_reading) && $stable(humidity))

    // a stalled result word holds
    `PM25C_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(corrected_pm))

    // an empty output means every stage can take a word
    `PM25C_ASSERT_NOW(a_empty_ready, !out_valid, in_ready)

    // saturation keeps results at or above the floor
    `PM25C_ASSERT_NOW(a_out_floor, out_valid, corrected_pm >= -12'sd4)

endmodule

bind pm25_humidity_correction pm25c_checker u_checker (.*);
